@@ design/ptbl_pkg.sv @@
// Shared constants, types and codes for the per-tenant token bucket limiter.
// No dependencies; every module of the block imports this package.
package ptbl_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int TOK_W       = 16 + FRAC_W;
	localparam int STAMP_W     = 48;
	localparam int RATE_W      = 32;
	localparam int BURST_W     = 16;
	localparam int LIMIT_W     = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int RATE_SH     = 24 - FRAC_W;
	localparam int PROD_W      = STAMP_W + RATE_W;
	localparam int MAC_W       = 16;
	localparam int MAC_STEPS   = STAMP_W / MAC_W;
	localparam int STEP_W      = $clog2(MAC_STEPS + 1);

	localparam logic [TOK_W-1:0] TOK_ONE = TOK_W'(1) << FRAC_W;

	typedef enum logic [1:0] {
		OP_ALLOW     = 2'd0,
		OP_QUERY     = 2'd1,
		OP_RESET_KEY = 2'd2,
		OP_RESET_ALL = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   addr;
		logic [KEY_W-1:0]   key;
		logic [TOK_W-1:0]   tokens;
		logic [STAMP_W-1:0] stamp;
	} slot_wr_t;

	typedef struct packed {
		logic               start;
		logic [STAMP_W-1:0] elapsed;
		logic [RATE_W-1:0]  rate;
		logic [TOK_W-1:0]   tokens;
		logic [TOK_W-1:0]   cap;
	} refill_req_t;

	typedef struct packed {
		logic             done;
		logic [TOK_W-1:0] tokens;
	} refill_rsp_t;

endpackage

@@ design/ptbl_slot_mem.sv @@
// Slot storage: key, token count and refill stamp of each table entry.
// One write port, one read port with registered data. Uses ptbl_pkg.
module ptbl_slot_mem (
	input  logic                        clk,
	input  logic [ptbl_pkg::IDX_W-1:0]  raddr,
	input  ptbl_pkg::slot_wr_t          wr,
	output logic [ptbl_pkg::KEY_W-1:0]  rd_key,
	output logic [ptbl_pkg::TOK_W-1:0]  rd_tokens,
	output logic [ptbl_pkg::STAMP_W-1:0] rd_stamp
);
	import ptbl_pkg::*;

	logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
	logic [TOK_W-1:0]   tok_mem   [TABLE_DEPTH];
	logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];

	logic [KEY_W-1:0]   rd_key_q;
	logic [TOK_W-1:0]   rd_tok_q;
	logic [STAMP_W-1:0] rd_stamp_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			key_mem[wr.addr]   <= wr.key;
			tok_mem[wr.addr]   <= wr.tokens;
			stamp_mem[wr.addr] <= wr.stamp;
		end
		rd_key_q   <= key_mem[raddr];
		rd_tok_q   <= tok_mem[raddr];
		rd_stamp_q <= stamp_mem[raddr];
	end

	assign rd_key    = rd_key_q;
	assign rd_tokens = rd_tok_q;
	assign rd_stamp  = rd_stamp_q;

endmodule

@@ design/ptbl_refill.sv @@
// Refill unit: elapsed * rate over several 16-bit multiply-accumulate steps,
// then saturation at the bucket cap. Uses ptbl_pkg.
module ptbl_refill (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptbl_pkg::refill_req_t req,
	output ptbl_pkg::refill_rsp_t rsp
);
	import ptbl_pkg::*;

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [STAMP_W-1:0]  el_q;
	logic [RATE_W-1:0]   rate_q;
	logic [TOK_W-1:0]    tok_q;
	logic [TOK_W-1:0]    cap_q;
	logic [PROD_W-1:0]   acc_q;
	refill_rsp_t         rsp_q;

	logic [MAC_W-1:0]          chunk;
	logic [MAC_W+RATE_W-1:0]   part;
	logic [PROD_W-1:0]         mac;
	logic [TOK_W-1:0]          head;
	logic [TOK_W+RATE_SH-1:0]  head_sh;
	logic                      sat;
	logic [TOK_W-1:0]          sum;
	logic [TOK_W-1:0]          result;

	always_comb begin
		// most significant chunk first, shift the accumulator up each step
		chunk   = el_q[STAMP_W-1 -: MAC_W];
		part    = chunk * rate_q;
		mac     = {acc_q[PROD_W-MAC_W-1:0], {MAC_W{1'b0}}}
			+ {{(PROD_W-MAC_W-RATE_W){1'b0}}, part};
		head    = cap_q - tok_q;
		head_sh = {head, {RATE_SH{1'b0}}};
		sat     = (|acc_q[PROD_W-1:TOK_W+RATE_SH]) || (acc_q[TOK_W+RATE_SH-1:0] >= head_sh);
		sum     = tok_q + acc_q[TOK_W+RATE_SH-1:RATE_SH];
		result  = ((tok_q >= cap_q) || sat) ? cap_q : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			el_q   <= '0;
			rate_q <= '0;
			tok_q  <= '0;
			cap_q  <= '0;
			acc_q  <= '0;
			rsp_q  <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				el_q   <= req.elapsed;
				rate_q <= req.rate;
				tok_q  <= req.tokens;
				cap_q  <= req.cap;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(MAC_STEPS)) begin
					busy_q       <= 1'b0;
					rsp_q.done   <= 1'b1;
					rsp_q.tokens <= result;
				end else begin
					acc_q  <= mac;
					el_q   <= el_q << MAC_W;
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

@@ design/per_tenant_token_bucket_limiter.sv @@
// Top level of the per-tenant token bucket limiter: command sequencer, slot
// scan, valid bits and config registers. Uses ptbl_pkg, ptbl_slot_mem, ptbl_refill.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  command  | start in, busy out         | opcode, tenant_key, now_ticks
//  result   | done out (one-cycle pulse) | granted, tokens_left, key_found,
//           |                            | entry_evicted
//  config   | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
// A command scans all 16 slots through the single memory read port, one slot
// a cycle. Query, reset and allow-miss pulse done once the scan is over; an
// allow hit also waits for the three-step multiply-accumulate of the refill
// unit. busy is high from the accepting edge until the done cycle; a new
// command may start in the done cycle.
// Reset clears every valid bit at once; no clearing pass is needed.
// Results cannot be held off: done marks the only cycle they are presented.
module per_tenant_token_bucket_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [31:0]                       tenant_key,
	input  logic [47:0]                       now_ticks,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptbl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptbl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output logic                              granted,
	output logic [15:0]                       tokens_left,
	output logic                              key_found,
	output logic                              entry_evicted
);
	import ptbl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_REFILL
	} state_t;

	state_t state_q;

	logic [BURST_W-1:0] burst_q;
	logic [RATE_W-1:0]  rate_q;
	logic [LIMIT_W-1:0] limit_q;

	op_t                op_q;
	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] now_q;

	logic [CNT_W-1:0]   rd_idx_q;
	logic               chk_vld_q;
	logic [IDX_W-1:0]   chk_idx_q;

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [TOK_W-1:0]   hit_tok_q;
	logic [STAMP_W-1:0] hit_stamp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pick_vld_q;
	logic [IDX_W-1:0]   pick_idx_q;
	logic [STAMP_W-1:0] pick_stamp_q;
	logic               free_vld_q;
	logic [IDX_W-1:0]   free_idx_q;

	logic [TABLE_DEPTH-1:0] valid_q;

	logic               done_q;
	logic               granted_q;
	logic [BURST_W-1:0] left_q;
	logic               found_q;
	logic               evicted_q;

	logic [KEY_W-1:0]   rd_key;
	logic [TOK_W-1:0]   rd_tokens;
	logic [STAMP_W-1:0] rd_stamp;
	slot_wr_t           wr;
	refill_req_t        rf_req;
	refill_rsp_t        rf_rsp;

	logic               accept;
	logic               slot_v;
	logic [31:0]        lim_eff;
	logic               evict;
	logic               have_slot;
	logic [IDX_W-1:0]   ins_idx;
	logic [BURST_W-1:0] burst_m1;
	logic               grant_hit;
	logic [TOK_W-1:0]   hit_new_tok;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	// hold register writes off while a command is in flight
	assign cfg_ready = (state_q == S_IDLE);

	always_comb begin
		slot_v = valid_q[chk_idx_q];

		// limit 0 acts as 1, anything above the table depth as the depth
		lim_eff = {{(32-LIMIT_W){1'b0}}, limit_q};
		if (lim_eff == 32'd0) begin
			lim_eff = 32'd1;
		end else if (lim_eff > 32'(TABLE_DEPTH)) begin
			lim_eff = 32'(TABLE_DEPTH);
		end

		evict     = ({{(32-CNT_W){1'b0}}, cnt_q} >= lim_eff) && pick_vld_q;
		have_slot = evict || free_vld_q;
		// after eviction the lowest free slot is the lower of the two
		ins_idx   = (evict && (!free_vld_q || (pick_idx_q < free_idx_q)))
			? pick_idx_q : free_idx_q;
		burst_m1  = (burst_q == '0) ? '0 : burst_q - BURST_W'(1);

		grant_hit   = (rf_rsp.tokens >= TOK_ONE);
		hit_new_tok = grant_hit ? rf_rsp.tokens - TOK_ONE : rf_rsp.tokens;

		wr        = '0;
		wr.key    = key_q;
		wr.stamp  = now_q;
		wr.addr   = ins_idx;
		wr.tokens = {burst_m1, {FRAC_W{1'b0}}};
		if ((state_q == S_DECIDE) && (op_q == OP_ALLOW) && !hit_q && have_slot) begin
			wr.we = 1'b1;
		end else if ((state_q == S_REFILL) && rf_rsp.done) begin
			wr.we     = 1'b1;
			wr.addr   = hit_idx_q;
			wr.tokens = hit_new_tok;
		end

		rf_req         = '0;
		rf_req.start   = (state_q == S_DECIDE) && (op_q == OP_ALLOW) && hit_q;
		// time going back counts as no elapsed time
		rf_req.elapsed = (now_q >= hit_stamp_q) ? now_q - hit_stamp_q : '0;
		rf_req.rate    = rate_q;
		rf_req.tokens  = hit_tok_q;
		rf_req.cap     = {burst_q, {FRAC_W{1'b0}}};
	end

	ptbl_slot_mem u_mem (
		.clk       (clk),
		.raddr     (rd_idx_q[IDX_W-1:0]),
		.wr        (wr),
		.rd_key    (rd_key),
		.rd_tokens (rd_tokens),
		.rd_stamp  (rd_stamp)
	);

	ptbl_refill u_refill (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rf_req),
		.rsp    (rf_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= BURST_W'(10);
			rate_q  <= RATE_W'(16777);
			limit_q <= LIMIT_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BURST: burst_q <= cfg_data[BURST_W-1:0];
				CFG_RATE:  rate_q  <= cfg_data[RATE_W-1:0];
				CFG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ALLOW;
			key_q        <= '0;
			now_q        <= '0;
			rd_idx_q     <= '0;
			chk_vld_q    <= 1'b0;
			chk_idx_q    <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_tok_q    <= '0;
			hit_stamp_q  <= '0;
			cnt_q        <= '0;
			pick_vld_q   <= 1'b0;
			pick_idx_q   <= '0;
			pick_stamp_q <= '0;
			free_vld_q   <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			done_q       <= 1'b0;
			granted_q    <= 1'b0;
			left_q       <= '0;
			found_q      <= 1'b0;
			evicted_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= S_SCAN;
						op_q       <= op_t'(opcode);
						key_q      <= tenant_key[KEY_W-1:0];
						now_q      <= now_ticks;
						rd_idx_q   <= '0;
						chk_vld_q  <= 1'b0;
						hit_q      <= 1'b0;
						cnt_q      <= '0;
						pick_vld_q <= 1'b0;
						free_vld_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// issue one read a cycle, check the slot read the cycle before
					if (rd_idx_q != CNT_W'(TABLE_DEPTH)) begin
						rd_idx_q  <= rd_idx_q + CNT_W'(1);
						chk_vld_q <= 1'b1;
						chk_idx_q <= rd_idx_q[IDX_W-1:0];
					end else begin
						chk_vld_q <= 1'b0;
					end
					if (chk_vld_q) begin
						if (slot_v) begin
							cnt_q <= cnt_q + CNT_W'(1);
							if (!hit_q && (rd_key == key_q)) begin
								hit_q       <= 1'b1;
								hit_idx_q   <= chk_idx_q;
								hit_tok_q   <= rd_tokens;
								hit_stamp_q <= rd_stamp;
							end
							if (!pick_vld_q || (rd_stamp < pick_stamp_q)) begin
								pick_vld_q   <= 1'b1;
								pick_idx_q   <= chk_idx_q;
								pick_stamp_q <= rd_stamp;
							end
						end else if (!free_vld_q) begin
							free_vld_q <= 1'b1;
							free_idx_q <= chk_idx_q;
						end
					end
					if (!chk_vld_q && (rd_idx_q == CNT_W'(TABLE_DEPTH))) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					granted_q <= 1'b0;
					left_q    <= burst_q;
					found_q   <= hit_q;
					evicted_q <= 1'b0;
					state_q   <= S_IDLE;
					done_q    <= 1'b1;
					unique case (op_q)
						OP_ALLOW: begin
							if (hit_q) begin
								// hold the result until the refill unit returns
								state_q <= S_REFILL;
								done_q  <= 1'b0;
							end else begin
								granted_q <= 1'b1;
								evicted_q <= evict;
								if (evict) begin
									valid_q[pick_idx_q] <= 1'b0;
								end
								if (have_slot) begin
									valid_q[ins_idx] <= 1'b1;
									left_q           <= burst_m1;
								end
							end
						end
						OP_QUERY: begin
							if (hit_q) begin
								left_q <= hit_tok_q[TOK_W-1:FRAC_W];
							end
						end
						OP_RESET_KEY: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
							end
						end
						OP_RESET_ALL: begin
							valid_q <= '0;
							found_q <= 1'b0;
						end
						default: ;
					endcase
				end
				S_REFILL: begin
					if (rf_rsp.done) begin
						granted_q <= grant_hit;
						left_q    <= hit_new_tok[TOK_W-1:FRAC_W];
						found_q   <= 1'b1;
						evicted_q <= 1'b0;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign granted       = granted_q;
	assign tokens_left   = left_q;
	assign key_found     = found_q;
	assign entry_evicted = evicted_q;

endmodule

@@ tb/ptbl_bucket_checker.sv @@
`timescale 1ns / 1ps
// Bucket table predictor and result checker for the per-tenant token bucket limiter.
// Watches the command, config and result channels. Depends on ptbl_pkg.
module ptbl_bucket_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [ptbl_pkg::KEY_W-1:0]      tenant_key,
	input  logic [ptbl_pkg::STAMP_W-1:0]    now_ticks,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [ptbl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptbl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            done,
	input  logic                            granted,
	input  logic [15:0]                     tokens_left,
	input  logic                            key_found,
	input  logic                            entry_evicted,
	output int                              mismatches,
	output int                              outstanding
);
	import ptbl_pkg::*;

	typedef struct {
		bit        granted;
		bit [15:0] left;
		bit        found;
		bit        evicted;
	} bucket_reply_t;

	bucket_reply_t owed_replies[$];

	bit               live  [TABLE_DEPTH];
	bit [KEY_W-1:0]   owner [TABLE_DEPTH];
	bit [TOK_W-1:0]   level [TABLE_DEPTH];
	bit [STAMP_W-1:0] stamp [TABLE_DEPTH];

	bit [BURST_W-1:0] burst;
	bit [RATE_W-1:0]  rate;
	bit [LIMIT_W-1:0] limit;

	function automatic bit [TOK_W-1:0] topped_up(bit [TOK_W-1:0] tok, bit [STAMP_W-1:0] el);
		bit [TOK_W-1:0]  cap;
		bit [TOK_W-1:0]  head;
		bit [PROD_W-1:0] prod;
		bit [PROD_W-1:0] add;
		cap = TOK_W'(burst) << FRAC_W;
		if (tok >= cap)
			return cap;
		head = cap - tok;
		if (rate == 0 || el == 0)
			return tok;
		// full-width product: anything past 64 bits lands far above the headroom
		prod = PROD_W'(el) * PROD_W'(rate);
		add = prod >> RATE_SH;
		if (add >= PROD_W'(head))
			return cap;
		return tok + add[TOK_W-1:0];
	endfunction

	function automatic bucket_reply_t serve_request(op_t op, bit [KEY_W-1:0] k,
			bit [STAMP_W-1:0] now);
		bucket_reply_t    r;
		int               hit;
		int               pick;
		int               free;
		int               cnt;
		int               lim;
		bit [STAMP_W-1:0] el;
		hit = -1;
		pick = -1;
		free = -1;
		cnt = 0;
		r = '{granted: 1'b0, left: burst, found: 1'b0, evicted: 1'b0};
		foreach (live[i])
			if (live[i] && owner[i] == k && hit < 0)
				hit = i;
		case (op)
		OP_ALLOW: begin
			if (hit < 0) begin
				lim = (limit == 0) ? 1 : int'(limit);
				if (lim > TABLE_DEPTH)
					lim = TABLE_DEPTH;
				foreach (live[i])
					if (live[i])
						cnt++;
				// at the limit: drop the oldest stamp, lowest slot on ties
				if (cnt >= lim) begin
					foreach (live[i])
						if (live[i] && (pick < 0 || stamp[i] < stamp[pick]))
							pick = i;
					if (pick >= 0) begin
						live[pick] = 1'b0;
						r.evicted = 1'b1;
					end
				end
				foreach (live[i])
					if (!live[i] && free < 0)
						free = i;
				if (free >= 0) begin
					live[free] = 1'b1;
					owner[free] = k;
					level[free] = (burst == 0) ? '0 : TOK_W'(burst - 1'b1) << FRAC_W;
					stamp[free] = now;
					r.left = level[free][FRAC_W +: 16];
				end
				r.granted = 1'b1;
			end else begin
				el = (now >= stamp[hit]) ? now - stamp[hit] : '0;
				r.found = 1'b1;
				level[hit] = topped_up(level[hit], el);
				stamp[hit] = now;
				if (level[hit] >= TOK_ONE) begin
					level[hit] -= TOK_ONE;
					r.granted = 1'b1;
				end
				r.left = level[hit][FRAC_W +: 16];
			end
		end
		OP_QUERY: begin
			if (hit >= 0) begin
				r.found = 1'b1;
				r.left = level[hit][FRAC_W +: 16];
			end
		end
		OP_RESET_KEY: begin
			if (hit >= 0) begin
				r.found = 1'b1;
				live[hit] = 1'b0;
			end
		end
		default: begin
			foreach (live[i])
				live[i] = 1'b0;
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bucket_reply_t want;
		int            bad;
		bad = 0;
		if (!arst_n) begin
			owed_replies.delete();
			foreach (live[i])
				live[i] = 1'b0;
			burst = 16'd10;
			rate = 32'd16777;
			limit = 5'd16;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// compare first: a new command may be accepted in the result cycle
			if (done) begin
				if (owed_replies.size() == 0) begin
					$error("result beat with no command waiting");
					bad++;
				end else begin
					want = owed_replies.pop_front();
					if (granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, granted);
						bad++;
					end
					if (tokens_left !== want.left) begin
						$error("tokens_left: expected %0d, got %0d", want.left, tokens_left);
						bad++;
					end
					if (key_found !== want.found) begin
						$error("key_found: expected %0d, got %0d", want.found, key_found);
						bad++;
					end
					if (entry_evicted !== want.evicted) begin
						$error("entry_evicted: expected %0d, got %0d", want.evicted,
							entry_evicted);
						bad++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_BURST: burst = cfg_data[BURST_W-1:0];
				CFG_RATE:  rate = cfg_data[RATE_W-1:0];
				CFG_LIMIT: limit = cfg_data[LIMIT_W-1:0];
				default: ;
				endcase
			end
			if (start && !busy)
				owed_replies.push_back(serve_request(op_t'(opcode), tenant_key, now_ticks));
			outstanding <= owed_replies.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

@@ tb/per_tenant_token_bucket_limiter_test.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the per-tenant token bucket limiter: directed cases, then
// randomized tenant traffic over several configurations. Uses ptbl_pkg and ptbl_bucket_checker.
module per_tenant_token_bucket_limiter_test;
	import ptbl_pkg::*;

	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 240;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam logic [47:0] TICK_MAX = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            opcode = OP_ALLOW;
	logic [31:0]           tenant_key = '0;
	logic [47:0]           now_ticks = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_BURST;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  done;
	logic                  granted;
	logic [15:0]           tokens_left;
	logic                  key_found;
	logic                  entry_evicted;

	int mismatches;
	int outstanding;
	int cycles = 0;
	bit gaps_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	per_tenant_token_bucket_limiter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.tenant_key   (tenant_key),
		.now_ticks    (now_ticks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.granted      (granted),
		.tokens_left  (tokens_left),
		.key_found    (key_found),
		.entry_evicted(entry_evicted)
	);

	ptbl_bucket_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.tenant_key   (tenant_key),
		.now_ticks    (now_ticks),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.granted      (granted),
		.tokens_left  (tokens_left),
		.key_found    (key_found),
		.entry_evicted(entry_evicted),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// hold start high across back-to-back beats; drop it only for a gap
	task automatic issue(input op_t op, input logic [31:0] key, input logic [47:0] at);
		if (gaps_on && $urandom_range(99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		tenant_key <= key;
		now_ticks <= at;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		if (gaps_on && $urandom_range(99) < 29) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// junk in the unused upper bits of burst and limit writes
	task automatic set_regs(input logic [15:0] b, input logic [31:0] r, input logic [4:0] l);
		drain();
		write_reg(CFG_BURST, {16'($urandom), b});
		write_reg(CFG_RATE, r);
		write_reg(CFG_LIMIT, {27'($urandom), l});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] pool [24];
		logic [31:0] key;
		logic [47:0] tick;
		logic [47:0] step;
		logic [47:0] at;
		logic [15:0] b;
		logic [31:0] r;
		logic [4:0]  l;
		op_t         op;
		int          pool_n;
		int          roll;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: miss, hit, queries, time extremes, time going back, clears
		issue(OP_ALLOW, 32'h0, 48'h0);
		issue(OP_ALLOW, 32'h0, 48'h0);
		issue(OP_QUERY, 32'h0, 48'h0);
		issue(OP_QUERY, 32'hFFFF_FFFF, 48'h0);
		issue(OP_ALLOW, 32'hFFFF_FFFF, TICK_MAX);
		issue(OP_ALLOW, 32'h0, TICK_MAX);
		issue(OP_ALLOW, 32'h0, 48'd3);
		issue(OP_ALLOW, 32'h5555_5555, 48'd4);
		issue(OP_RESET_KEY, 32'h0, 48'd4);
		issue(OP_RESET_KEY, 32'h0, 48'd4);
		issue(OP_RESET_ALL, 32'h0, 48'd4);
		issue(OP_QUERY, 32'h5555_5555, 48'd4);

		// zero burst, no refill, single tenant
		set_regs(16'd0, 32'd0, 5'd1);
		issue(OP_ALLOW, 32'hAAAA_AAAA, 48'h8000_0000_0000);
		issue(OP_ALLOW, 32'hAAAA_AAAA, 48'h8000_0000_0000);
		issue(OP_ALLOW, 32'h1234_5678, 48'h8000_0000_0001);
		issue(OP_QUERY, 32'hAAAA_AAAA, 48'h8000_0000_0001);

		// widest burst and rate, limit above table depth
		set_regs(16'hFFFF, 32'hFFFF_FFFF, 5'd31);
		issue(OP_ALLOW, 32'd1, 48'd10);
		issue(OP_ALLOW, 32'd2, 48'd11);
		issue(OP_ALLOW, 32'd3, 48'd12);
		issue(OP_ALLOW, 32'd4, 48'd13);
		issue(OP_ALLOW, 32'd1, 48'd20);

		// lower the limit below the occupancy: each miss evicts just one
		set_regs(16'hFFFF, 32'hFFFF_FFFF, 5'd2);
		issue(OP_ALLOW, 32'd5, 48'd21);
		issue(OP_QUERY, 32'd2, 48'd21);
		issue(OP_ALLOW, 32'd6, 48'd21);

		for (int p = 0; p < PHASES; p++) begin
			// one long stretch with back-to-back beats
			gaps_on = (p != 2);
			case ($urandom_range(5))
			0: b = 16'd0;
			1: b = 16'd1;
			2: b = 16'($urandom_range(2, 12));
			3: b = 16'hFFFF;
			4: b = 16'($urandom_range(1, 65535));
			default: b = 16'd10;
			endcase
			case ($urandom_range(6))
			0: r = 32'd0;
			1: r = 32'd1;
			2: r = 32'h0100_0000;
			3: r = 32'd16777;
			4: r = 32'hFFFF_FFFF;
			5: r = $urandom();
			default: r = $urandom_range(1, 1 << 22);
			endcase
			case ($urandom_range(5))
			0: l = 5'd0;
			1: l = 5'd1;
			2: l = 5'd2;
			3: l = 5'($urandom_range(3, 15));
			4: l = 5'd16;
			default: l = 5'($urandom_range(17, 31));
			endcase
			set_regs(b, r, l);

			pool_n = $urandom_range(2, 24);
			for (int i = 0; i < pool_n; i++)
				pool[i] = $urandom();
			tick = {16'($urandom), 32'($urandom)};
			if ($urandom_range(1))
				tick = 48'($urandom_range(0, 1000));

			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 30)
					step = '0;
				else if (roll < 80)
					step = 48'($urandom_range(1, 16));
				else if (roll < 93)
					step = 48'($urandom_range(17, 1 << 20));
				else
					step = 48'($urandom());
				tick += step;
				at = tick;
				if ($urandom_range(99) < 3)
					at = tick - 48'($urandom_range(1, 500));
				if ($urandom_range(99) < 8)
					key = $urandom();
				else
					key = pool[$urandom_range(pool_n - 1)];
				roll = $urandom_range(99);
				if (roll < 68)
					op = OP_ALLOW;
				else if (roll < 83)
					op = OP_QUERY;
				else if (roll < 97)
					op = OP_RESET_KEY;
				else
					op = OP_RESET_ALL;
				issue(op, key, at);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
